/* rtl/core/prp_pkg.sv */
// ----------------------------------------------------------------------------
// prp_pkg - shared types and constants for the roll/yaw polar converter
// Controller command/status bundles, state encoding, CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

  // fixed-point layout of the CORDIC
  localparam int GuardBits = 16;   // fraction bits added below the sample
  localparam int ZW        = 34;   // angle accumulator, units of pi/2^31
  localparam int AtanIdxW  = 5;    // index into the 32-entry angle table
  localparam int GainW     = 32;   // width of the 1/K constant
  localparam int MulChunkW = 16;   // bits of x taken per multiply cycle

  // 1/K in Q0.32
  localparam logic [GainW-1:0] GainInv = 32'd2608131497;

  // atan(2^-i) in units of pi/2^31
  localparam logic [31:0] AtanTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // sample kinds
  localparam logic KindRoll = 1'b0;
  localparam logic KindYaw  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;  // store the incoming sample
    logic load;     // pre-rotate the held pair into x/y/z
    logic iter;     // one CORDIC micro-rotation
    logic mul;      // one gain-correction multiply chunk
    logic emit;     // round, saturate, load output register
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic last_chunk;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/prp_if.sv */
// ----------------------------------------------------------------------------
// prp_if - valid/ready channels of the polar converter
// Sample input channel and polar result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface prp_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface prp_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] angle;
  logic        [SAMPLE_WIDTH-1:0] radius;

  modport source (output valid, output angle, output radius, input ready);
  modport sink   (input valid, input angle, input radius, output ready);
endinterface

`default_nettype wire

/* rtl/core/paired_rect_to_polar.sv */
// ----------------------------------------------------------------------------
// paired_rect_to_polar - roll/yaw pair to angle and radius
// Holds the latest roll and yaw samples and converts each completed pair.
// ----------------------------------------------------------------------------
// Samples arrive on the feed channel tagged roll (kind 0) or yaw (kind 1),
// Q1.(SAMPLE_WIDTH-1). The block keeps the newest value of each kind; a
// repeated kind simply overwrites the held value. Once both kinds have been
// seen it produces one result on the result channel: angle = atan2(roll,yaw)
// in units of pi/2^(SAMPLE_WIDTH-1) (+pi saturates to the largest code) and
// radius = sqrt(roll^2 + yaw^2) unsigned Q1.(SAMPLE_WIDTH-1), and forgets
// both. A sample that does not complete a pair is simply captured. A sample
// that completes a pair is captured and then occupies the block, with the
// feed channel closed, until its result has been rounded into the output
// register. The steps are: capture, pre-rotation into the right half plane,
// the micro-rotations of the single shared CORDIC rotator, the 16-bit slices
// of the 16x32 gain-correction multiplier one after another, and rounding
// into the output register. The output register lets the next samples be
// taken while a result waits; a second result waits in the last step until
// the first has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module paired_rect_to_polar #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  prp_in_if.sink    feed,
  prp_out_if.source result
);
  import prp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing, presence flags, result-register occupancy
  prp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed.valid),
    .kind      (feed.kind),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // held samples, CORDIC rotator, gain multiply, result payload
  prp_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .status (status),
    .kind   (feed.kind),
    .sample (feed.sample),
    .angle  (result.angle),
    .radius (result.radius)
  );

endmodule

`default_nettype wire

/* rtl/core/prp_dp.sv */
// ----------------------------------------------------------------------------
// prp_dp - datapath of the polar converter
// Held samples, shared CORDIC rotator, chunked gain multiply, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  prp_pkg::cmd_t                  cmd,
  output prp_pkg::status_t               status,
  input  logic                           kind,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] angle,
  output logic        [SAMPLE_WIDTH-1:0] radius
);
  import prp_pkg::*;

  localparam int XW       = SAMPLE_WIDTH + GuardBits + 2;
  localparam int NChunk   = (XW + MulChunkW - 1) / MulChunkW;
  localparam int PadW     = NChunk * MulChunkW;
  localparam int AccW     = PadW + GainW;
  localparam int RqW      = PadW + 1 - GuardBits;
  localparam int StepW    = $clog2(CORDIC_STEPS);
  localparam int ChunkW   = $clog2(NChunk);
  localparam int AngShift = 32 - SAMPLE_WIDTH;

  localparam logic signed [ZW-1:0] ZRound  = ZW'((35'd1 << AngShift) >> 1);
  localparam logic signed [ZW-1:0] ZQuarter = ZW'(35'd1 << 30);
  localparam logic signed [ZW-1:0] AMax    = ZW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ZW-1:0] AMin    = -AMax - ZW'(1);
  localparam logic [PadW:0]        RHalf   = (PadW + 1)'(1) << (GuardBits - 1);

  logic signed [SAMPLE_WIDTH-1:0] held_roll;
  logic signed [SAMPLE_WIDTH-1:0] held_yaw;
  logic signed [XW-1:0]           x;
  logic signed [XW-1:0]           y;
  logic signed [ZW-1:0]           z;
  logic                           is_zero;
  logic [StepW-1:0]               step;
  logic [ChunkW-1:0]              chunk;
  logic [AccW-1:0]                acc;

  // pre-rotation into the right half plane
  logic signed [XW-1:0] xs, ys, x_ld, y_ld;
  logic signed [ZW-1:0] z_ld;

  always_comb begin
    xs = XW'(held_yaw) <<< GuardBits;
    ys = XW'(held_roll) <<< GuardBits;
    x_ld = xs;
    y_ld = ys;
    z_ld = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x_ld = ys;
        y_ld = -xs;
        z_ld = ZQuarter;
      end else begin
        x_ld = -ys;
        y_ld = xs;
        z_ld = -ZQuarter;
      end
    end
  end

  // one micro-rotation; >>> floors like the arithmetic shift it models
  logic signed [XW-1:0] dx, dy, x_it, y_it;
  logic signed [ZW-1:0] tz, z_it;

  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    tz = ZW'(AtanTab[AtanIdxW'(step)]);
    if (!y[XW-1]) begin
      x_it = x + dx;
      y_it = y - dy;
      z_it = z + tz;
    end else begin
      x_it = x - dx;
      y_it = y + dy;
      z_it = z - tz;
    end
  end

  // gain correction: x is never negative after pre-rotation
  logic [PadW-1:0]            x_pad;
  logic [MulChunkW-1:0]       x_part;
  logic [MulChunkW+GainW-1:0] prod;

  always_comb begin
    x_pad  = PadW'(unsigned'(x));
    x_part = x_pad[chunk*MulChunkW +: MulChunkW];
    prod   = x_part * GainInv;
  end

  // output rounding and saturation
  logic [PadW:0]                  rsum;
  logic [RqW-1:0]                 rq;
  logic [SAMPLE_WIDTH-1:0]        radius_next;
  logic signed [ZW-1:0]           zr, za;
  logic signed [SAMPLE_WIDTH-1:0] angle_next;

  always_comb begin
    rsum = (PadW + 1)'(acc[AccW-1:GainW]) + RHalf;
    rq   = rsum[PadW:GuardBits];
    if (|rq[RqW-1:SAMPLE_WIDTH]) begin
      radius_next = '1;
    end else begin
      radius_next = rq[SAMPLE_WIDTH-1:0];
    end
    zr = z + ZRound;
    za = zr >>> AngShift;
    if (za > AMax) begin
      angle_next = AMax[SAMPLE_WIDTH-1:0];
    end else if (za < AMin) begin
      angle_next = AMin[SAMPLE_WIDTH-1:0];
    end else begin
      angle_next = za[SAMPLE_WIDTH-1:0];
    end
    if (is_zero) begin
      radius_next = '0;
      angle_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (kind == KindYaw) begin
        held_yaw <= sample;
      end else begin
        held_roll <= sample;
      end
    end
    if (cmd.load) begin
      x       <= x_ld;
      y       <= y_ld;
      z       <= z_ld;
      is_zero <= (held_roll == '0) && (held_yaw == '0);
      step    <= '0;
      chunk   <= '0;
      acc     <= '0;
    end
    if (cmd.iter) begin
      x    <= x_it;
      y    <= y_it;
      z    <= z_it;
      step <= step + StepW'(1);
    end
    if (cmd.mul) begin
      acc   <= acc + (AccW'(prod) << (chunk * MulChunkW));
      chunk <= chunk + ChunkW'(1);
    end
    if (cmd.emit) begin
      angle  <= angle_next;
      radius <= radius_next;
    end
  end

  assign status.last_step  = (step == StepW'(CORDIC_STEPS - 1));
  assign status.last_chunk = (chunk == ChunkW'(NChunk - 1));

endmodule

`default_nettype wire

/* rtl/core/prp_ctrl.sv */
// ----------------------------------------------------------------------------
// prp_ctrl - sequencer of the polar converter
// Tracks which components are present and steps the datapath through a pair.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output prp_pkg::cmd_t     cmd,
  input  prp_pkg::status_t  status
);
  import prp_pkg::*;

  state_t state, state_next;
  logic   roll_present, roll_present_next;
  logic   yaw_present, yaw_present_next;
  logic   out_full, out_full_next;
  logic   accept, pair;

  assign accept    = in_valid && in_ready;
  assign pair      = (kind == KindYaw) ? roll_present : yaw_present;
  assign out_valid = out_full;

  always_comb begin
    state_next        = state;
    roll_present_next = roll_present;
    yaw_present_next  = yaw_present;
    cmd               = '0;
    in_ready          = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          if (pair) begin
            roll_present_next = 1'b0;
            yaw_present_next  = 1'b0;
            state_next        = ST_LOAD;
          end else if (kind == KindYaw) begin
            yaw_present_next = 1'b1;
          end else begin
            roll_present_next = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (status.last_step) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (status.last_chunk) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_full || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_full_next = cmd.emit || (out_full && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      roll_present <= 1'b0;
      yaw_present  <= 1'b0;
      out_full     <= 1'b0;
    end else begin
      state        <= state_next;
      roll_present <= roll_present_next;
      yaw_present  <= yaw_present_next;
      out_full     <= out_full_next;
    end
  end

  // a result never overwrites one that has not been transferred
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_full || out_ready))
    else $error("result register overwritten");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_pair_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && pair) |=> (state == ST_LOAD && !roll_present && !yaw_present))
    else $error("completed pair did not start conversion");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_full && !out_ready) |=> (state == ST_DONE))
    else $error("conversion left while result blocked");

endmodule

`default_nettype wire
